// ----- hdl/mandalay_fold_dilation_iteration_top_defines.svh -----
// Assertion macros for the fold iteration block.
// Included by the top level only; no other dependencies.
`ifndef MANDALAY_FOLD_DILATION_ITERATION_TOP_DEFINES_SVH
`define MANDALAY_FOLD_DILATION_ITERATION_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MFD_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked out of reset
`define MFD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/mfd_pkg.sv -----
// Shared constants and types for the fold iteration block.
// No dependencies; used by the top level and the divider.
package mfd_pkg;

	localparam int DE_W      = 48;
	localparam int DE_FRAC   = 24;
	localparam int WEIGHT_W  = 40;
	localparam int RAD_W     = 39;
	localparam int MAT_W     = 60;
	localparam int MENT_W    = 20;
	localparam int MENT_FRAC = 18;
	localparam int FACT_W    = 64;
	localparam int CFG_W     = 60;
	localparam int CFG_IDX_W = 3;

	localparam logic [DE_W-1:0]   DE_MAX   = {DE_W{1'b1}};
	localparam logic [DE_W-1:0]   DE_ONE   = DE_W'(1) << DE_FRAC;
	localparam logic [FACT_W-1:0] FACT_MAX = {FACT_W{1'b1}};

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT  = 3'd0,
		CFG_MIN_RSQ = 3'd1,
		CFG_MAX_RSQ = 3'd2,
		CFG_SCALE   = 3'd3,
		CFG_ROT_EN  = 3'd4,
		CFG_ROW0    = 3'd5,
		CFG_ROW1    = 3'd6,
		CFG_ROW2    = 3'd7
	} cfg_idx_t;

	// Reset values: w = 0.8, squared radii 0.25 and 1.0, scale 2.0, identity matrix
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 40'd214748365;
	localparam logic [RAD_W-1:0]    MINR_RST   = 39'd67108864;
	localparam logic [RAD_W-1:0]    MAXR_RST   = 39'd268435456;
	localparam logic [WEIGHT_W-1:0] SCALE_RST  = 40'd536870912;
	localparam logic [MAT_W-1:0]    ROW0_RST   = 60'd288230376151711744;
	localparam logic [MAT_W-1:0]    ROW1_RST   = 60'd274877906944;
	localparam logic [MAT_W-1:0]    ROW2_RST   = 60'd262144;

endpackage

// ----- hdl/mfd_div.sv -----
// Pipelined restoring divider: one quotient bit per stage, side data rides along.
// Depends on mfd_pkg (factor width and saturation value).
module mfd_div #(
	parameter int NW = 67,
	parameter int SW = 169
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [NW-1:0]               numer,
	input  logic [mfd_pkg::FACT_W-1:0]  dvs,
	input  logic [SW-1:0]               side,
	output logic                        out_vld,
	output logic [mfd_pkg::FACT_W-1:0]  quot,
	output logic [SW-1:0]               out_side
);

	localparam int FW = mfd_pkg::FACT_W;
	localparam int QX = (NW > FW) ? NW : FW + 1;

	logic [FW-1:0] rem_s  [NW];
	logic [NW-1:0] quo_s  [NW];
	logic [FW-1:0] dvs_s  [NW];
	logic [SW-1:0] side_s [NW];
	logic [NW-1:0] vld_s;
	logic [QX-1:0] qx;

	for (genvar k = 0; k < NW; k++) begin : g_stage
		logic [FW-1:0] rem_p;
		logic [NW-1:0] quo_p;
		logic [FW-1:0] dvs_p;
		logic [SW-1:0] side_p;
		logic          vld_p;
		logic [FW:0]   trial;
		logic [FW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign quo_p  = '0;
			assign dvs_p  = dvs;
			assign side_p = side;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign quo_p  = quo_s[k-1];
			assign dvs_p  = dvs_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		assign trial = {rem_p, numer[NW-1-k]};
		assign ge    = trial >= {1'b0, dvs_p};
		assign diff  = trial - {1'b0, dvs_p};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[FW-1:0] : trial[FW-1:0];
				quo_s[k]  <= {quo_p[NW-2:0], ge};
				dvs_s[k]  <= dvs_p;
				side_s[k] <= side_p;
			end
		end
	end

	// quotient saturates to the factor range
	assign qx       = QX'(quo_s[NW-1]);
	assign quot     = (qx > QX'(mfd_pkg::FACT_MAX)) ? mfd_pkg::FACT_MAX : qx[FW-1:0];
	assign out_vld  = vld_s[NW-1];
	assign out_side = side_s[NW-1];

endmodule

// ----- hdl/mandalay_fold_dilation_iteration_top.sv -----
// Mandalay fold iteration: blend, spherical fold, scale and rotation pipeline.
// Depends on mfd_pkg, mfd_div and the assertion macro header.
//
// Usage:
// - Input channel in_valid/in_ready takes a point (in_x, in_y, in_z) and its
//   distance factor in_de; output channel out_valid/out_ready returns one
//   result request per input request, in order.
// - Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   request is in flight; writes take effect at once.
// - The pipeline holds six front stages, one divider stage per quotient bit
//   of the fold factor, and seven back stages ending in the output
//   register.
// - Throughput is one request per cycle while the output is not stalled; the
//   bit-serial divider pipeline sets the depth but not the rate.
// - The whole pipeline advances whenever the output register is empty or
//   being taken. A stalled receiver freezes every stage; nothing is lost or
//   repeated and in_ready drops until the result is taken.
// - Reset clears all valid bits and loads the default registers:
//   weight 0.8, squared radii 0.25 and 1.0, scale 2.0, rotation off, identity matrix.
`include "mandalay_fold_dilation_iteration_top_defines.svh"

module mandalay_fold_dilation_iteration_top #(
	parameter int COORD_WIDTH     = 40,
	parameter int COORD_FRAC_BITS = 28
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mfd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfd_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [COORD_WIDTH-1:0]     in_x,
	input  logic signed [COORD_WIDTH-1:0]     in_y,
	input  logic signed [COORD_WIDTH-1:0]     in_z,
	input  logic [mfd_pkg::DE_W-1:0]          in_de,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [COORD_WIDTH-1:0]     out_x,
	output logic signed [COORD_WIDTH-1:0]     out_y,
	output logic signed [COORD_WIDTH-1:0]     out_z,
	output logic [mfd_pkg::DE_W-1:0]          out_de
);

	localparam int CW   = COORD_WIDTH;
	localparam int F    = COORD_FRAC_BITS;
	localparam int MW   = CW - 1;
	localparam int DW   = mfd_pkg::DE_W;
	localparam int FW   = mfd_pkg::FACT_W;
	localparam int WW   = mfd_pkg::WEIGHT_W;
	localparam int RW   = mfd_pkg::RAD_W;
	localparam int EW   = mfd_pkg::MENT_W;
	localparam int HW   = FW / 2;
	localparam int DH   = DW / 2;
	localparam int WP   = WW + CW;
	localparam int PW   = CW + FW + 2;
	localparam int SQW  = (2 * CW + 2 > FW + 2) ? 2 * CW + 2 : FW + 2;
	localparam int NW   = RW + F;
	localparam int FPW  = CW + FW + 1;
	localparam int PFW  = CW + HW + 1;
	localparam int PDW  = DH + HW;
	localparam int DFW  = DW + FW;
	localparam int SPW  = CW + WW;
	localparam int PSW  = DH + WW;
	localparam int DSW  = DW + WW + 1;
	localparam int RPW  = CW + EW;
	localparam int RSW  = RPW + 2;
	localparam int SW   = 3 * CW + DW + 1;

	localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic [MW-1:0] C03 = MW'(((64'd3 << F) + 64'd5) / 64'd10);

	// Saturate a wide signed value to the coordinate range
	function automatic logic signed [CW-1:0] csat(input logic signed [PW-1:0] x);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(CMAX);
		lo = PW'(CMIN);
		if (x > hi) begin
			csat = CMAX;
		end else if (x < lo) begin
			csat = CMIN;
		end else begin
			csat = x[CW-1:0];
		end
	endfunction

	// Absolute value; the most negative code maps to the largest positive one
	function automatic logic [MW-1:0] cabs(input logic signed [CW-1:0] t);
		logic signed [CW-1:0] neg;
		neg = -t;
		if (t == CMIN) begin
			cabs = CMAX[MW-1:0];
		end else if (t[CW-1]) begin
			cabs = neg[MW-1:0];
		end else begin
			cabs = t[MW-1:0];
		end
	endfunction

	// Configuration registers
	logic signed [WW-1:0]          weight_q;
	logic [RW-1:0]                 minr_q;
	logic [RW-1:0]                 maxr_q;
	logic signed [WW-1:0]          scale_q;
	logic                          rot_q;
	logic [mfd_pkg::MAT_W-1:0]     row_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= mfd_pkg::WEIGHT_RST;
			minr_q   <= mfd_pkg::MINR_RST;
			maxr_q   <= mfd_pkg::MAXR_RST;
			scale_q  <= mfd_pkg::SCALE_RST;
			rot_q    <= 1'b0;
			row_q[0] <= mfd_pkg::ROW0_RST;
			row_q[1] <= mfd_pkg::ROW1_RST;
			row_q[2] <= mfd_pkg::ROW2_RST;
		end else if (cfg_we) begin
			unique case (mfd_pkg::cfg_idx_t'(cfg_index))
				mfd_pkg::CFG_WEIGHT:  weight_q <= cfg_wdata[WW-1:0];
				mfd_pkg::CFG_MIN_RSQ: minr_q   <= cfg_wdata[RW-1:0];
				mfd_pkg::CFG_MAX_RSQ: maxr_q   <= cfg_wdata[RW-1:0];
				mfd_pkg::CFG_SCALE:   scale_q  <= cfg_wdata[WW-1:0];
				mfd_pkg::CFG_ROT_EN:  rot_q    <= cfg_wdata[0];
				mfd_pkg::CFG_ROW0:    row_q[0] <= cfg_wdata;
				mfd_pkg::CFG_ROW1:    row_q[1] <= cfg_wdata;
				mfd_pkg::CFG_ROW2:    row_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Global advance: output register empty or being drained
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Pipeline valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic valid_s7, valid_s8, valid_s9, valid_s10, valid_s11, valid_s12;
	logic valid_s13;
	logic div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			valid_s4  <= 1'b0;
			valid_s5  <= 1'b0;
			valid_s6  <= 1'b0;
			valid_s7  <= 1'b0;
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			valid_s3  <= valid_s2;
			valid_s4  <= valid_s3;
			valid_s5  <= valid_s4;
			valid_s6  <= valid_s5;
			valid_s7  <= div_vld;
			valid_s8  <= valid_s7;
			valid_s9  <= valid_s8;
			valid_s10 <= valid_s9;
			valid_s11 <= valid_s10;
			valid_s12 <= valid_s11;
			valid_s13 <= valid_s12;
		end
	end

	// S1: absolute values
	logic [MW-1:0] a_s1 [3];
	logic [DW-1:0] de_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= cabs(in_x);
			a_s1[1] <= cabs(in_y);
			a_s1[2] <= cabs(in_z);
			de_s1   <= in_de;
		end
	end

	// S2: sort into descending order with three compare-swaps
	logic [MW-1:0] srt [3];
	logic [MW-1:0] a_s2 [3];
	logic [DW-1:0] de_s2;

	always_comb begin
		logic [MW-1:0] tmp;
		tmp = '0;
		srt = a_s1;
		if (srt[2] > srt[1]) begin
			tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
		end
		if (srt[1] > srt[0]) begin
			tmp = srt[0]; srt[0] = srt[1]; srt[1] = tmp;
		end
		if (srt[2] > srt[1]) begin
			tmp = srt[1]; srt[1] = srt[2]; srt[2] = tmp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2  <= srt;
			de_s2 <= de_s1;
		end
	end

	// S3: weight times distance below the 0.3 floor
	logic [MW-1:0]         dgap [3];
	logic signed [WP-1:0]  prod_s3 [3];
	logic [MW-1:0]         a_s3 [3];
	logic [DW-1:0]         de_s3;

	for (genvar i = 0; i < 3; i++) begin : g_gap
		assign dgap[i] = (a_s2[i] < C03) ? C03 - a_s2[i] : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s3[i] <= WP'(weight_q) * WP'($signed({1'b0, dgap[i]}));
			end
			a_s3  <= a_s2;
			de_s3 <= de_s2;
		end
	end

	// S4: blended component
	logic signed [CW-1:0] v_s4 [3];
	logic [DW-1:0]        de_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s4[i] <= csat(PW'($signed({1'b0, a_s3[i]})) + (PW'(prod_s3[i]) >>> F));
			end
			de_s4 <= de_s3;
		end
	end

	// S5: sum of squares
	logic [CW-1:0]        vmag [3];
	logic [SQW-1:0]       sqsum_s5;
	logic signed [CW-1:0] v_s5 [3];
	logic [DW-1:0]        de_s5;

	for (genvar i = 0; i < 3; i++) begin : g_mag
		assign vmag[i] = v_s4[i][CW-1] ? CW'(-v_s4[i]) : CW'(v_s4[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqsum_s5 <= SQW'(vmag[0]) * SQW'(vmag[0]) + SQW'(vmag[1]) * SQW'(vmag[1])
				+ SQW'(vmag[2]) * SQW'(vmag[2]);
			v_s5  <= v_s4;
			de_s5 <= de_s4;
		end
	end

	// S6: squared radius against the two shells, pick the divisor
	logic [SQW-1:0]       rr_wide;
	logic [FW-1:0]        rr;
	logic                 lt_min;
	logic                 lt_max;
	logic [FW-1:0]        dvs_s6;
	logic                 fold_s6;
	logic signed [CW-1:0] v_s6 [3];
	logic [DW-1:0]        de_s6;

	assign rr_wide = sqsum_s5 >> F;
	assign rr      = (rr_wide > SQW'(mfd_pkg::FACT_MAX)) ? mfd_pkg::FACT_MAX : rr_wide[FW-1:0];
	assign lt_min  = rr < FW'(minr_q);
	assign lt_max  = rr < FW'(maxr_q);

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s6  <= lt_min ? FW'(minr_q) : rr;
			fold_s6 <= lt_min || lt_max;
			v_s6    <= v_s5;
			de_s6   <= de_s5;
		end
	end

	// Fold factor max_r2 / divisor through the bit-serial divider pipeline
	logic [SW-1:0]        side_in;
	logic [SW-1:0]        side_out;
	logic [FW-1:0]        factor;
	logic                 d_fold;
	logic [DW-1:0]        d_de;
	logic signed [CW-1:0] d_v [3];

	assign side_in = {fold_s6, de_s6, v_s6[2], v_s6[1], v_s6[0]};
	assign {d_fold, d_de, d_v[2], d_v[1], d_v[0]} = side_out;

	mfd_div #(
		.NW (NW),
		.SW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (valid_s6),
		.numer    ({maxr_q, {F{1'b0}}}),
		.dvs      (dvs_s6),
		.side     (side_in),
		.out_vld  (div_vld),
		.quot     (factor),
		.out_side (side_out)
	);

	// S7: fold partial products, factor split into halves, de split into halves
	logic signed [PFW-1:0] pfl_s7 [3];
	logic signed [PFW-1:0] pfh_s7 [3];
	logic [PDW-1:0]        pd_s7 [4];
	logic                  fold_s7;
	logic signed [CW-1:0]  v_s7 [3];
	logic [DW-1:0]         de_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pfl_s7[i] <= PFW'(d_v[i]) * PFW'($signed({1'b0, factor[HW-1:0]}));
				pfh_s7[i] <= PFW'(d_v[i]) * PFW'($signed({1'b0, factor[FW-1:HW]}));
			end
			pd_s7[0] <= PDW'(d_de[DH-1:0]) * PDW'(factor[HW-1:0]);
			pd_s7[1] <= PDW'(d_de[DH-1:0]) * PDW'(factor[FW-1:HW]);
			pd_s7[2] <= PDW'(d_de[DW-1:DH]) * PDW'(factor[HW-1:0]);
			pd_s7[3] <= PDW'(d_de[DW-1:DH]) * PDW'(factor[FW-1:HW]);
			fold_s7  <= d_fold;
			v_s7     <= d_v;
			de_s7    <= d_de;
		end
	end

	// S8: combine partial products into full fold products
	logic signed [FPW-1:0] pf_s8 [3];
	logic [DFW-1:0]        pfd_s8;
	logic                  fold_s8;
	logic signed [CW-1:0]  v_s8 [3];
	logic [DW-1:0]         de_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pf_s8[i] <= (FPW'(pfh_s7[i]) <<< HW) + FPW'(pfl_s7[i]);
			end
			pfd_s8  <= DFW'(pd_s7[0]) + (DFW'(pd_s7[1]) << HW) + (DFW'(pd_s7[2]) << DH)
				+ (DFW'(pd_s7[3]) << (DH + HW));
			fold_s8 <= fold_s7;
			v_s8    <= v_s7;
			de_s8   <= de_s7;
		end
	end

	// S9: apply fold when inside the outer shell
	logic [DFW-1:0]       pfd_sh;
	logic signed [CW-1:0] v_s9 [3];
	logic [DW-1:0]        de_s9;

	assign pfd_sh = pfd_s8 >> F;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_s9[i] <= fold_s8 ? csat(PW'(pf_s8[i] >>> F)) : v_s8[i];
			end
			if (!fold_s8) begin
				de_s9 <= de_s8;
			end else if (pfd_sh > DFW'(mfd_pkg::DE_MAX)) begin
				de_s9 <= mfd_pkg::DE_MAX;
			end else begin
				de_s9 <= pfd_sh[DW-1:0];
			end
		end
	end

	// S10: scale products, de split into halves
	logic [WW-1:0]         smag;
	logic signed [SPW-1:0] ps_s10 [3];
	logic [PSW-1:0]        pdl_s10;
	logic [PSW-1:0]        pdh_s10;

	assign smag = scale_q[WW-1] ? WW'(-scale_q) : WW'(scale_q);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ps_s10[i] <= SPW'(v_s9[i]) * SPW'(scale_q);
			end
			pdl_s10 <= PSW'(de_s9[DH-1:0]) * PSW'(smag);
			pdh_s10 <= PSW'(de_s9[DW-1:DH]) * PSW'(smag);
		end
	end

	// S11: scaled point and de*|scale| + 1
	logic [DSW-1:0]       de_sum;
	logic signed [CW-1:0] vs_s11 [3];
	logic [DW-1:0]        de_s11;

	assign de_sum = (((DSW'(pdh_s10) << DH) + DSW'(pdl_s10)) >> F) + DSW'(mfd_pkg::DE_ONE);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				vs_s11[i] <= csat(PW'(ps_s10[i] >>> F));
			end
			de_s11 <= (de_sum > DSW'(mfd_pkg::DE_MAX)) ? mfd_pkg::DE_MAX : de_sum[DW-1:0];
		end
	end

	// S12: rotation matrix products, entry (i,j) times coordinate j
	logic signed [EW-1:0]  ment [3][3];
	logic signed [RPW-1:0] mp_s12 [3][3];
	logic signed [CW-1:0]  vs_s12 [3];
	logic [DW-1:0]         de_s12;

	for (genvar i = 0; i < 3; i++) begin : g_row
		for (genvar j = 0; j < 3; j++) begin : g_col
			assign ment[i][j] = row_q[i][mfd_pkg::MAT_W-1-EW*j -: EW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s12[i][j] <= RPW'(ment[i][j]) * RPW'(vs_s11[j]);
				end
			end
			vs_s12 <= vs_s11;
			de_s12 <= de_s11;
		end
	end

	// S13: row sums (or the scaled point when rotation is off) and output register
	logic signed [RSW-1:0] rsum [3];
	logic signed [CW-1:0]  res_s13 [3];
	logic [DW-1:0]         de_s13;

	for (genvar i = 0; i < 3; i++) begin : g_rsum
		assign rsum[i] = RSW'(mp_s12[i][0]) + RSW'(mp_s12[i][1]) + RSW'(mp_s12[i][2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				res_s13[i] <= rot_q ? csat(PW'(rsum[i] >>> mfd_pkg::MENT_FRAC)) : vs_s12[i];
			end
			de_s13 <= de_s12;
		end
	end

	assign out_valid = valid_s13;
	assign out_x     = res_s13[0];
	assign out_y     = res_s13[1];
	assign out_z     = res_s13[2];
	assign out_de    = de_s13;

	// Checks
	`MFD_ASSERT_NOW(a_de_floor, out_valid, out_de >= mfd_pkg::DE_ONE, "de below one")
	`MFD_ASSERT_NEXT(a_rot_bypass, valid_s12 && en && !rot_q, out_x == $past(vs_s12[0]), "rotation bypass broken")
	`MFD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, $stable(v_s4[0]) && $stable(valid_s4), "pipeline moved under stall")

endmodule
